### rtl/core/dqd_pkg.sv
// ----------------------------------------------------------------------------
// dqd_pkg
// Types and codes shared by the deque cell row and its controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dqd_pkg;

   localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [2:0] CMD_POP_BACK   = 3'd1;
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [2:0] CMD_DELETE     = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic        [2:0]  command;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic        [4:0]  entry_count;
      logic        [1:0]  status;
   } rsp_type;

   // per-cycle controls broadcast along the cell row
   typedef struct packed {
      logic capture;
      logic push_back;
      logic push_front;
      logic pop_back;
      logic pop_front;
      logic remove;
   } cell_ctl_type;

endpackage

`default_nettype wire

### rtl/core/deque_with_delete_by_value_unit.sv
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_unit
// Double-ended queue of signed 32-bit values with delete of the first match.
// ----------------------------------------------------------------------------
// Each item passes through three steps: acceptance in the idle state, a
// match step in which every cell compares its entry with the item's value
// and registers the match, and an apply step in which the row shifts and
// the result is written to the output register. The registered compare in
// the cells is why the match and apply steps are separate. A new item is
// accepted as soon as the previous one has left the cell row, even while its
// result still waits in the output register; a result that has not been taken holds the next item in its apply step.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_delete_by_value_unit #(
   parameter int CAPACITY = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dqd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dqd_pkg::rsp_type      rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE        = CW'(1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_MATCH = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   dqd_pkg::req_type      req_ff, req_in;
   logic [CW-1:0]         count_ff, count_in;
   dqd_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   dqd_pkg::cell_ctl_type ctl;

   logic signed [31:0] value_w [CAPACITY];
   logic               hit_w   [CAPACITY+1];
   logic signed [31:0] pick_w  [CAPACITY+1];

   logic        apply_fire;
   logic        empty;
   logic        full;
   logic        found;
   logic [1:0]  status;
   logic [31:0] count_wide;

   assign req_ready  = state_ff == S_IDLE;
   assign apply_fire = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign empty      = count_ff == '0;
   assign full       = count_ff == FULL_COUNT;

   assign hit_w[0]  = 1'b0;
   assign pick_w[0] = 32'sd0;
   assign found     = hit_w[CAPACITY];

   // cell row, front at index 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_v;
      logic signed [31:0] right_v;
      if (i == 0) begin : g_front
         assign left_v = req_ff.value;
      end else begin : g_mid_l
         assign left_v = value_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_back
         assign right_v = value_w[i];
      end else begin : g_mid_r
         assign right_v = value_w[i+1];
      end
      dqd_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_value   (req_ff.value),
         .count       (count_ff),
         .left_value  (left_v),
         .right_value (right_v),
         .hit_in      (hit_w[i]),
         .hit_out     (hit_w[i+1]),
         .pick_in     (pick_w[i]),
         .pick_out    (pick_w[i+1]),
         .value_out   (value_w[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      status       = dqd_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            ctl.capture = 1'b1;
            state_in    = S_APPLY;
         end
         S_APPLY: begin
            if (apply_fire) begin
               case (req_ff.command)
                  dqd_pkg::CMD_PUSH_BACK: begin
                     if (full) begin
                        status = dqd_pkg::ST_FULL;
                     end else begin
                        ctl.push_back = 1'b1;
                        count_in      = count_ff + ONE;
                     end
                  end
                  dqd_pkg::CMD_PUSH_FRONT: begin
                     if (full) begin
                        status = dqd_pkg::ST_FULL;
                     end else begin
                        ctl.push_front = 1'b1;
                        count_in       = count_ff + ONE;
                     end
                  end
                  dqd_pkg::CMD_POP_BACK: begin
                     if (empty) begin
                        status = dqd_pkg::ST_EMPTY;
                     end else begin
                        ctl.pop_back = 1'b1;
                        count_in     = count_ff - ONE;
                     end
                  end
                  dqd_pkg::CMD_POP_FRONT: begin
                     if (empty) begin
                        status = dqd_pkg::ST_EMPTY;
                     end else begin
                        ctl.pop_front = 1'b1;
                        count_in      = count_ff - ONE;
                     end
                  end
                  dqd_pkg::CMD_DELETE: begin
                     if (!found) begin
                        status = dqd_pkg::ST_NOT_FOUND;
                     end else begin
                        ctl.remove = 1'b1;
                        count_in   = count_ff - ONE;
                     end
                  end
                  default: begin
                     status = dqd_pkg::ST_OK;
                  end
               endcase
               rsp_in.popped_value = pick_w[CAPACITY];
               rsp_in.entry_count  = count_wide[4:0];
               rsp_in.status       = status;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign count_wide = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### rtl/core/dqd_cell.sv
// ----------------------------------------------------------------------------
// dqd_cell
// One entry of the deque: holds a value, registers its match against the
// searched value, and takes its neighbour's value when the row shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module dqd_cell #(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  wire logic                 clock,
   input  wire dqd_pkg::cell_ctl_type ctl,
   input  wire logic signed [31:0]   new_value,
   input  wire logic        [CW-1:0] count,
   input  wire logic signed [31:0]   left_value,
   input  wire logic signed [31:0]   right_value,
   input  wire logic                 hit_in,
   output logic                      hit_out,
   input  wire logic signed [31:0]   pick_in,
   output logic signed [31:0]        pick_out,
   output logic signed [31:0]        value_out
);

   localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
   localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);
   localparam logic          IS_FRONT = (IDX == 0);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic               match_ff;
   logic               occupied;
   logic               at_tail;
   logic               at_last;
   logic               sel;

   assign occupied = count > MY_IDX;
   assign at_tail  = count == MY_IDX;
   assign at_last  = count == NEXT_IDX;

   assign hit_out = hit_in | match_ff;

   assign sel      = (ctl.pop_back && at_last) || (ctl.pop_front && IS_FRONT && occupied);
   assign pick_out = pick_in | (sel ? value_ff : 32'sd0);

   always_comb begin
      value_in = value_ff;
      if (ctl.push_back && at_tail) begin
         value_in = new_value;
      end else if (ctl.push_front) begin
         value_in = left_value;
      end else if (ctl.pop_front) begin
         value_in = right_value;
      end else if (ctl.remove && hit_out) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (ctl.capture) begin
         match_ff <= occupied && (value_ff == new_value);
      end
   end

   assign value_out = value_ff;

endmodule

`default_nettype wire
